### hw/rtl/html_entity_stream_decoder_macros.svh
// Assertion macros shared by the checker of the entity decoder.
`ifndef HTML_ENTITY_STREAM_DECODER_MACROS_SVH
`define HTML_ENTITY_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define HED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("entity decoder check failed");

// Next-cycle implication, masked while reset is asserted.
`define HED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("entity decoder check failed");

// Next-cycle implication that also holds through reset.
`define HED_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("entity decoder check failed");

`endif

### hw/rtl/hed_pkg.sv
package hed_pkg;

    localparam int MAX_WINDOW_DEF = 33;
    localparam int NAME_LEN       = 6;
    localparam int NUM_NAMES      = 49;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;

    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] CP_SAT  = 21'h1FFFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    // Entity names, right-justified, last character in the low byte.
    localparam logic [8*NAME_LEN-1:0] NAME_TAB [NUM_NAMES] = '{
        "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
        "trade", "hellip", "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo",
        "laquo", "raquo", "bull", "middot", "dagger", "deg", "plusmn", "times",
        "divide", "minus", "ne", "le", "ge", "larr", "rarr", "harr",
        "darr", "uarr", "euro", "pound", "yen", "cent", "sect", "para",
        "frac12", "frac14", "frac34", "ensp", "emsp", "thinsp",
        "shy", "zwj", "zwnj"
    };

    // Code point of each name; zero emits nothing.
    localparam logic [20:0] CP_TAB [NUM_NAMES] = '{
        21'h26, 21'h3C, 21'h3E, 21'h22, 21'h27, 21'h20, 21'hA9, 21'hAE,
        21'h2122, 21'h2026, 21'h2014, 21'h2013, 21'h2018, 21'h2019, 21'h201C, 21'h201D,
        21'hAB, 21'hBB, 21'h2022, 21'hB7, 21'h2020, 21'hB0, 21'hB1, 21'hD7,
        21'hF7, 21'h2212, 21'h2260, 21'h2264, 21'h2265, 21'h2190, 21'h2192, 21'h2194,
        21'h2193, 21'h2191, 21'h20AC, 21'hA3, 21'hA5, 21'hA2, 21'hA7, 21'hB6,
        21'hBD, 21'hBC, 21'hBE, 21'h20, 21'h20, 21'h20,
        21'h0, 21'h0, 21'h0
    };

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_Q_READ,
        OP_Q_LATCH,
        OP_PASS,
        OP_START,
        OP_CAPT,
        OP_RESOLVE,
        OP_EMIT,
        OP_FAIL_AMP,
        OP_FAIL_RD,
        OP_FAIL_WR,
        OP_LAST
    } t_op;

    typedef struct packed {
        t_op  op;
        logic trig;
    } t_cmd;

    typedef struct packed {
        logic capturing;
        logic is_amp;
        logic is_semi;
        logic len_zero;
        logic len_full;
        logic resolve_ok;
        logic emit_done;
        logic q_empty;
        logic pend_valid;
        logic can_push;
    } t_stat;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  cnt;
    } t_utf8;

    typedef struct packed {
        logic        hit;
        logic [20:0] cp;
    } t_name_hit;

    function automatic logic [2:0] name_len(input logic [8*NAME_LEN-1:0] n);
        logic [2:0] c;
        c = '0;
        for (int k = 0; k < NAME_LEN; k++) begin
            if (n[8*k +: 8] != 8'h00) c = c + 3'd1;
        end
        return c;
    endfunction

    // Match the first body bytes against the name table.
    function automatic t_name_hit name_lookup(input logic [NAME_LEN-1:0][7:0] sh,
                                              input logic [2:0] len);
        logic [8*NAME_LEN-1:0] key;
        t_name_hit r;
        key = '0;
        r   = '0;
        for (int k = 0; k < NAME_LEN; k++) begin
            if (3'(k) < len) key = {key[8*NAME_LEN-9:0], sh[k]};
        end
        for (int e = 0; e < NUM_NAMES; e++) begin
            if (!r.hit && NAME_TAB[e] == key && name_len(NAME_TAB[e]) == len) begin
                r.hit = 1'b1;
                r.cp  = CP_TAB[e];
            end
        end
        return r;
    endfunction

    // Encode a code point, first byte in the low byte.
    function automatic t_utf8 utf8_encode(input logic [20:0] v);
        t_utf8 r;
        r = '0;
        if (v < 21'h80) begin
            r.bytes[7:0] = v[7:0];
            r.cnt        = 3'd1;
        end else if (v < 21'h800) begin
            r.bytes[7:0]  = 8'hC0 | {3'b000, v[10:6]};
            r.bytes[15:8] = 8'h80 | {2'b00, v[5:0]};
            r.cnt         = 3'd2;
        end else if (v < 21'h10000) begin
            r.bytes[7:0]   = 8'hE0 | {4'b0000, v[15:12]};
            r.bytes[15:8]  = 8'h80 | {2'b00, v[11:6]};
            r.bytes[23:16] = 8'h80 | {2'b00, v[5:0]};
            r.cnt          = 3'd3;
        end else begin
            r.bytes[7:0]   = 8'hF0 | {5'b00000, v[20:18]};
            r.bytes[15:8]  = 8'h80 | {2'b00, v[17:12]};
            r.bytes[23:16] = 8'h80 | {2'b00, v[11:6]};
            r.bytes[31:24] = 8'h80 | {2'b00, v[5:0]};
            r.cnt          = 3'd4;
        end
        return r;
    endfunction

endpackage

### hw/rtl/hed_ram.sv
module hed_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/hed_ctrl.sv
module hed_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    input  hed_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output hed_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_FAIL,
        S_FRD,
        S_FWR,
        S_EMIT,
        S_NEXT,
        S_QWAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   r_trig, n_trig;

    // Sequence one byte at a time: pass, capture, resolve, emit or replay.
    always_comb begin
        n_state      = r_state;
        n_flush      = r_flush;
        n_trig       = r_trig;
        o_cmd.op     = hed_pkg::OP_NONE;
        o_cmd.trig   = r_trig;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = hed_pkg::OP_LOAD_IN;
                    n_flush  = i_in_op;
                    n_state  = i_in_op ? S_NEXT : S_BYTE;
                end
            end
            S_BYTE: begin
                if (!i_stat.capturing) begin
                    if (i_stat.is_amp) begin
                        o_cmd.op = hed_pkg::OP_START;
                        n_state  = S_NEXT;
                    end else if (i_stat.can_push) begin
                        o_cmd.op = hed_pkg::OP_PASS;
                        n_state  = S_NEXT;
                    end
                end else if (i_stat.is_semi) begin
                    if (i_stat.resolve_ok) begin
                        o_cmd.op = hed_pkg::OP_RESOLVE;
                        n_state  = S_EMIT;
                    end else begin
                        n_trig  = 1'b1;
                        n_state = S_FAIL;
                    end
                end else if (!i_stat.len_full) begin
                    o_cmd.op = hed_pkg::OP_CAPT;
                    n_state  = S_NEXT;
                end else begin
                    n_trig  = 1'b1;
                    n_state = S_FAIL;
                end
            end
            S_FAIL: begin
                if (i_stat.can_push) begin
                    o_cmd.op = hed_pkg::OP_FAIL_AMP;
                    n_state  = S_FRD;
                end
            end
            S_FRD: begin
                if (i_stat.len_zero) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.op = hed_pkg::OP_FAIL_RD;
                    n_state  = S_FWR;
                end
            end
            S_FWR: begin
                o_cmd.op = hed_pkg::OP_FAIL_WR;
                n_state  = S_FRD;
            end
            S_EMIT: begin
                if (i_stat.emit_done) begin
                    n_state = S_NEXT;
                end else if (i_stat.can_push) begin
                    o_cmd.op = hed_pkg::OP_EMIT;
                end
            end
            S_NEXT: begin
                if (!i_stat.q_empty) begin
                    o_cmd.op = hed_pkg::OP_Q_READ;
                    n_state  = S_QWAIT;
                end else if (r_flush && i_stat.capturing) begin
                    n_trig  = 1'b0;
                    n_state = S_FAIL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QWAIT: begin
                o_cmd.op = hed_pkg::OP_Q_LATCH;
                n_state  = S_BYTE;
            end
            S_DONE: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.can_push) begin
                    o_cmd.op = hed_pkg::OP_LAST;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and item flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_trig  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_trig  <= n_trig;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/hed_dp.sv
module hed_dp #(
    parameter int MAX_WINDOW = hed_pkg::MAX_WINDOW_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hed_pkg::t_cmd  i_cmd,
    input  logic [7:0]     i_in_byte,
    output hed_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);

    localparam int BODY   = MAX_WINDOW - 1;
    localparam int LW     = $clog2(MAX_WINDOW);
    localparam int CAW    = $clog2(BODY);
    localparam int QAW    = $clog2(MAX_WINDOW + 1);
    localparam int QDEPTH = 2 ** QAW;

    logic [7:0]    r_cur;
    logic          r_capturing;
    logic [LW-1:0] r_len;
    logic [hed_pkg::NAME_LEN-1:0][7:0] r_sh;
    logic          r_num, r_hex, r_ndig, r_bad, r_sat;
    logic [20:0]   r_acc;
    logic [31:0]   r_emit;
    logic [2:0]    r_ecnt;
    logic [QAW-1:0] r_qh;
    logic          r_pend_v;
    logic [7:0]    r_pend_b;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ol;

    logic [LW-1:0] len_m1;
    logic [2:0]    len_name;
    logic          is_dec, is_hl, is_hu, dig_ok;
    logic [3:0]    dval;
    logic [24:0]   acc_mul, acc_nxt;
    logic          num_ok, resolve_ok;
    logic [20:0]   res_cp;
    hed_pkg::t_name_hit name_hit;
    hed_pkg::t_utf8     enc;
    logic          push_en;
    logic [7:0]    push_byte;
    logic          can_push;
    logic [7:0]    cap_rdata, q_rdata;
    logic          q_we;
    logic [7:0]    q_wdata;

    assign len_m1   = r_len - 1'b1;
    assign len_name = (r_len <= LW'(hed_pkg::NAME_LEN)) ? r_len[2:0] : 3'd7;

    // Decode a digit of the running numeric body.
    assign is_dec  = (r_cur >= 8'h30) && (r_cur <= 8'h39);
    assign is_hl   = r_hex && (r_cur >= 8'h61) && (r_cur <= 8'h66);
    assign is_hu   = r_hex && (r_cur >= 8'h41) && (r_cur <= 8'h46);
    assign dig_ok  = is_dec || is_hl || is_hu;
    assign dval    = is_dec ? r_cur[3:0] : r_cur[3:0] + 4'd9;
    assign acc_mul = r_hex ? {r_acc, 4'b0000}
                           : ({1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0});
    assign acc_nxt = acc_mul + 25'(dval);

    // Resolve the body on the closing semicolon.
    assign name_hit   = hed_pkg::name_lookup(r_sh, len_name);
    assign num_ok     = r_ndig && !r_bad && !r_sat && (r_acc != '0)
                        && !((r_acc >= hed_pkg::SURR_LO) && (r_acc <= hed_pkg::SURR_HI));
    assign resolve_ok = r_num ? num_ok : name_hit.hit;
    assign res_cp     = r_num ? r_acc : name_hit.cp;
    assign enc        = hed_pkg::utf8_encode(res_cp);

    assign can_push = !r_ov || i_out_ready;

    // Pick the byte to push toward the output.
    always_comb begin
        push_en   = 1'b0;
        push_byte = r_cur;
        unique case (i_cmd.op)
            hed_pkg::OP_PASS: push_en = 1'b1;
            hed_pkg::OP_EMIT: begin
                push_en   = 1'b1;
                push_byte = r_emit[7:0];
            end
            hed_pkg::OP_FAIL_AMP: begin
                push_en   = 1'b1;
                push_byte = hed_pkg::CH_AMP;
            end
            default: push_en = 1'b0;
        endcase
    end

    // Capture, numeric accumulation, replay and emit bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_len       <= '0;
            r_qh        <= '0;
            r_ecnt      <= '0;
        end else begin
            unique case (i_cmd.op)
                hed_pkg::OP_LOAD_IN: r_cur <= i_in_byte;
                hed_pkg::OP_Q_READ:  r_qh <= r_qh + 1'b1;
                hed_pkg::OP_Q_LATCH: r_cur <= q_rdata;
                hed_pkg::OP_START: begin
                    r_capturing <= 1'b1;
                    r_len       <= '0;
                    r_num       <= 1'b0;
                    r_hex       <= 1'b0;
                    r_ndig      <= 1'b0;
                    r_bad       <= 1'b0;
                    r_sat       <= 1'b0;
                    r_acc       <= '0;
                end
                hed_pkg::OP_CAPT: begin
                    r_len <= r_len + 1'b1;
                    if (r_len < LW'(hed_pkg::NAME_LEN)) r_sh[r_len[2:0]] <= r_cur;
                    if (r_len == '0) begin
                        r_num <= (r_cur == hed_pkg::CH_HASH);
                    end else if (r_num) begin
                        if (r_len == LW'(1)
                            && (r_cur == hed_pkg::CH_X_LO || r_cur == hed_pkg::CH_X_UP)) begin
                            r_hex <= 1'b1;
                        end else if (!dig_ok) begin
                            r_bad <= 1'b1;
                        end else begin
                            r_ndig <= 1'b1;
                            if (!r_sat) begin
                                if (acc_nxt > 25'(hed_pkg::CP_MAX)) begin
                                    r_sat <= 1'b1;
                                    r_acc <= hed_pkg::CP_SAT;
                                end else begin
                                    r_acc <= acc_nxt[20:0];
                                end
                            end
                        end
                    end
                end
                hed_pkg::OP_RESOLVE: begin
                    r_capturing <= 1'b0;
                    r_len       <= '0;
                    r_emit      <= enc.bytes;
                    r_ecnt      <= (res_cp == '0) ? 3'd0 : enc.cnt;
                end
                hed_pkg::OP_EMIT: begin
                    r_emit <= {8'h00, r_emit[31:8]};
                    r_ecnt <= r_ecnt - 3'd1;
                end
                hed_pkg::OP_FAIL_AMP: begin
                    r_capturing <= 1'b0;
                    if (i_cmd.trig) r_qh <= r_qh - 1'b1;
                end
                hed_pkg::OP_FAIL_RD: r_len <= len_m1;
                hed_pkg::OP_FAIL_WR: r_qh <= r_qh - 1'b1;
                default: r_len <= r_len;
            endcase
        end
    end

    // Hold one byte back so the last byte of an item can carry tlast.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (push_en) begin
                if (r_pend_v) begin
                    r_ov <= 1'b1;
                    r_ob <= r_pend_b;
                    r_ol <= 1'b0;
                end else if (i_out_ready) begin
                    r_ov <= 1'b0;
                end
                r_pend_v <= 1'b1;
                r_pend_b <= push_byte;
            end else if (i_cmd.op == hed_pkg::OP_LAST) begin
                r_ov     <= 1'b1;
                r_ob     <= r_pend_b;
                r_ol     <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Capture buffer: written at the fill point, read back in reverse on failure.
    hed_ram #(
        .WIDTH  (8),
        .DEPTH  (BODY),
        .ADDR_W (CAW)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == hed_pkg::OP_CAPT),
        .i_waddr (r_len[CAW-1:0]),
        .i_wdata (r_cur),
        .i_re    (i_cmd.op == hed_pkg::OP_FAIL_RD),
        .i_raddr (len_m1[CAW-1:0]),
        .o_rdata (cap_rdata)
    );

    // Replay queue: failures push at the front, replay pops from the front.
    assign q_we    = (i_cmd.op == hed_pkg::OP_FAIL_AMP && i_cmd.trig)
                     || (i_cmd.op == hed_pkg::OP_FAIL_WR);
    assign q_wdata = (i_cmd.op == hed_pkg::OP_FAIL_WR) ? cap_rdata : r_cur;

    hed_ram #(
        .WIDTH  (8),
        .DEPTH  (QDEPTH),
        .ADDR_W (QAW)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_qh - 1'b1),
        .i_wdata (q_wdata),
        .i_re    (i_cmd.op == hed_pkg::OP_Q_READ),
        .i_raddr (r_qh),
        .o_rdata (q_rdata)
    );

    assign o_stat.capturing  = r_capturing;
    assign o_stat.is_amp     = (r_cur == hed_pkg::CH_AMP);
    assign o_stat.is_semi    = (r_cur == hed_pkg::CH_SEMI);
    assign o_stat.len_zero   = (r_len == '0);
    assign o_stat.len_full   = (r_len == LW'(BODY));
    assign o_stat.resolve_ok = resolve_ok;
    assign o_stat.emit_done  = (r_ecnt == 3'd0);
    assign o_stat.q_empty    = (r_qh == '0);
    assign o_stat.pend_valid = r_pend_v;
    assign o_stat.can_push   = can_push;

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;

endmodule

### hw/rtl/html_entity_stream_decoder.sv
// HTML character reference decoder for a byte stream.
// Input channel s_axis: tdata[7:0] is a text byte, tuser=1 marks end of text
// (flushes a pending reference; tdata is then ignored). Output channel m_axis:
// tdata[7:0] is a decoded byte, tlast marks the final byte produced by one
// input beat; an input beat may produce no bytes at all.
// One input beat is taken at a time; s_axis_tready stays low until the block
// is through with it. A failed reference emits '&' and pushes the trigger
// byte, if any, and the body, read back in reverse from the capture buffer,
// onto the front of the replay queue; the capture buffer and replay queue
// each have a single read port.
// Each output byte is held until the next byte or the beat's end sets tlast.
// Reset clears the capture, the replay queue and the output register; the
// block accepts input in the first cycle after reset.
// When m_axis stalls, decoding stops at the next output byte and resumes once
// the output register frees; nothing is dropped.
module html_entity_stream_decoder #(
    parameter int MAX_WINDOW = hed_pkg::MAX_WINDOW_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] opcode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    hed_pkg::t_cmd  cmd;
    hed_pkg::t_stat stat;

    hed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    hed_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_byte   (s_axis_tdata),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

### hw/rtl/hed_chk.sv
`include "html_entity_stream_decoder_macros.svh"

module hed_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Hold a stalled output beat.
    `HED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Drop ready after taking a beat: one item at a time.
    `HED_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // While idle, only the closing beat of the last item can be waiting.
    `HED_ASSERT_NOW(a_idle_last, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid, m_axis_tlast)

    // Come out of reset with an empty output.
    `HED_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind html_entity_stream_decoder hed_chk u_chk (.*);

### tb/sv/html_entity_stream_decoder_tb.sv
`timescale 1ns / 1ps

module html_entity_stream_decoder_tb;

    localparam int  BODY_LIMIT  = hed_pkg::MAX_WINDOW_DEF - 1;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam bit  KIND_TEXT   = 1'b0;
    localparam bit  KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    t_in_beat  pending_beats[$];
    t_out_beat decoded_bytes[$];

    // predictor state
    logic [7:0] body_buf [hed_pkg::MAX_WINDOW_DEF];
    int         body_len;
    bit         in_ref;

    int  errors;
    int  cycles;
    int  beats_in;
    int  bytes_out;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stimulus_done;
    bit  hold_send;

    string ENTITY_NAMES [hed_pkg::NUM_NAMES] = '{
        "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
        "trade", "hellip", "mdash", "ndash", "lsquo", "rsquo", "ldquo", "rdquo",
        "laquo", "raquo", "bull", "middot", "dagger", "deg", "plusmn", "times",
        "divide", "minus", "ne", "le", "ge", "larr", "rarr", "harr",
        "darr", "uarr", "euro", "pound", "yen", "cent", "sect", "para",
        "frac12", "frac14", "frac34", "ensp", "emsp", "thinsp",
        "shy", "zwj", "zwnj"
    };
    int ENTITY_CPS [hed_pkg::NUM_NAMES] = '{
        'h26, 'h3C, 'h3E, 'h22, 'h27, 'h20, 'hA9, 'hAE,
        'h2122, 'h2026, 'h2014, 'h2013, 'h2018, 'h2019, 'h201C, 'h201D,
        'hAB, 'hBB, 'h2022, 'hB7, 'h2020, 'hB0, 'hB1, 'hD7,
        'hF7, 'h2212, 'h2260, 'h2264, 'h2265, 'h2190, 'h2192, 'h2194,
        'h2193, 'h2191, 'h20AC, 'hA3, 'hA5, 'hA2, 'hA7, 'hB6,
        'hBD, 'hBC, 'hBE, 'h20, 'h20, 'h20,
        0, 0, 0
    };

    html_entity_stream_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] opcode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void add_byte(ref logic [7:0] outs[$], input int b);
        outs = {outs, b[7:0]};
    endfunction

    function automatic void add_utf8(ref logic [7:0] outs[$], input int v);
        if (v < 'h80) begin
            add_byte(outs, v);
        end else if (v < 'h800) begin
            add_byte(outs, 'hC0 | (v >> 6));
            add_byte(outs, 'h80 | (v & 'h3F));
        end else if (v < 'h10000) begin
            add_byte(outs, 'hE0 | (v >> 12));
            add_byte(outs, 'h80 | ((v >> 6) & 'h3F));
            add_byte(outs, 'h80 | (v & 'h3F));
        end else begin
            add_byte(outs, 'hF0 | (v >> 18));
            add_byte(outs, 'h80 | ((v >> 12) & 'h3F));
            add_byte(outs, 'h80 | ((v >> 6) & 'h3F));
            add_byte(outs, 'h80 | (v & 'h3F));
        end
    endfunction

    // Resolve the held body; return 0 on a failed reference.
    function automatic bit resolve_ref(ref logic [7:0] outs[$]);
        bit         hex;
        int         i;
        int         base;
        int         acc;
        int         d;
        int         c;
        bit         sat;
        bit         same;
        if (body_len == 0) return 0;
        if (body_buf[0] == hed_pkg::CH_HASH) begin
            hex  = body_len > 1 && (body_buf[1] == hed_pkg::CH_X_LO ||
                                    body_buf[1] == hed_pkg::CH_X_UP);
            i    = hex ? 2 : 1;
            base = hex ? 16 : 10;
            acc  = 0;
            sat  = 0;
            if (i >= body_len) return 0;
            for (; i < body_len; i++) begin
                c = body_buf[i];
                if (c >= "0" && c <= "9") d = c - "0";
                else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
                else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
                else return 0;
                if (!sat) begin
                    acc = acc * base + d;
                    if (acc > hed_pkg::CP_MAX) begin
                        sat = 1;
                        acc = hed_pkg::CP_SAT;
                    end
                end
            end
            if (sat || acc == 0 || (acc >= hed_pkg::SURR_LO && acc <= hed_pkg::SURR_HI))
                return 0;
            add_utf8(outs, acc);
            return 1;
        end
        for (int e = 0; e < hed_pkg::NUM_NAMES; e++) begin
            if (ENTITY_NAMES[e].len() == body_len) begin
                same = 1;
                for (int k = 0; k < body_len; k++)
                    if (ENTITY_NAMES[e][k] != body_buf[k]) same = 0;
                if (same) begin
                    if (ENTITY_CPS[e] != 0) add_utf8(outs, ENTITY_CPS[e]);
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    // Emit '&' and push the body (plus trigger) back ahead of the rest.
    function automatic void abandon_ref(ref logic [7:0] outs[$], ref logic [7:0] work[$],
                                        input bit with_trig, input logic [7:0] trig);
        add_byte(outs, hed_pkg::CH_AMP);
        if (with_trig) work.push_front(trig);
        for (int i = body_len - 1; i >= 0; i--) work.push_front(body_buf[i]);
        in_ref   = 0;
        body_len = 0;
    endfunction

    // Decode one input beat into the expected output bytes.
    function automatic void predict_decode(input t_in_beat beat);
        logic [7:0] work[$];
        logic [7:0] outs[$];
        logic [7:0] b;
        t_out_beat  ob;
        if (beat.kind == KIND_TEXT) work = {work, beat.data};
        forever begin
            while (work.size() > 0) begin
                b = work.pop_front();
                if (!in_ref) begin
                    if (b == hed_pkg::CH_AMP) begin
                        in_ref   = 1;
                        body_len = 0;
                    end else begin
                        add_byte(outs, b);
                    end
                end else if (b == hed_pkg::CH_SEMI) begin
                    if (resolve_ref(outs)) begin
                        in_ref   = 0;
                        body_len = 0;
                    end else begin
                        abandon_ref(outs, work, 1, b);
                    end
                end else if (body_len < BODY_LIMIT) begin
                    body_buf[body_len] = b;
                    body_len++;
                end else begin
                    abandon_ref(outs, work, 1, b);
                end
            end
            if (beat.kind == KIND_FLUSH && in_ref) abandon_ref(outs, work, 0, 8'h00);
            else break;
        end
        foreach (outs[i]) begin
            ob.data = outs[i];
            ob.last = (i == outs.size() - 1);
            decoded_bytes = {decoded_bytes, ob};
        end
    endfunction

    task automatic queue_text(input string s);
        t_in_beat beat;
        for (int i = 0; i < s.len(); i++) begin
            beat.kind = KIND_TEXT;
            beat.data = s[i];
            pending_beats = {pending_beats, beat};
        end
    endtask

    task automatic queue_byte(input logic kind, input logic [7:0] data);
        t_in_beat beat;
        beat.kind = kind;
        beat.data = data;
        pending_beats = {pending_beats, beat};
    endtask

    // Build a random reference, well formed or broken in one of several ways.
    task automatic queue_random_ref();
        int    pick;
        int    n;
        string s;
        pick = $urandom_range(0, 9);
        queue_byte(KIND_TEXT, hed_pkg::CH_AMP);
        case (pick)
            0, 1, 2: begin
                queue_text(ENTITY_NAMES[$urandom_range(0, hed_pkg::NUM_NAMES - 1)]);
            end
            3: begin
                s = $sformatf("#%0d", $urandom_range(0, 'h10FFFF));
                queue_text(s);
            end
            4: begin
                s = ($urandom_range(0, 1) != 0) ? "#x" : "#X";
                s = {s, $sformatf("%0h", $urandom_range(0, 'h11FFFF))};
                queue_text(s);
            end
            5: begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) queue_byte(KIND_TEXT, 8'($urandom_range(0, 255)));
            end
            6: begin
                s = $sformatf("#x%0h", $urandom_range('hD7F0, 'hE010));
                queue_text(s);
            end
            7: begin
                n = $urandom_range(28, 34);
                for (int i = 0; i < n; i++)
                    queue_byte(KIND_TEXT, 8'($urandom_range("a", "z")));
            end
            default: begin
                queue_text(ENTITY_NAMES[$urandom_range(0, hed_pkg::NUM_NAMES - 1)]);
                queue_byte(KIND_TEXT, 8'($urandom_range(0, 255)));
            end
        endcase
        if ($urandom_range(0, 7) == 0) queue_byte(KIND_FLUSH, 8'($urandom_range(0, 255)));
        else queue_byte(KIND_TEXT, hed_pkg::CH_SEMI);
    endtask

    task automatic wait_drain();
        while (pending_beats.size() > 0 || s_axis_tvalid || decoded_bytes.size() > 0)
            @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        errors        = 0;
        stimulus_done = 0;
        hold_send     = 0;
        send_idle_pct = 9;
        recv_idle_pct = 75;
        body_len      = 0;
        in_ref        = 0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases
        queue_text("a&amp;&lt;&zwj;&frac34;");
        queue_text("&#65;&#x20AC;&#X1F600;&#1114111;");
        queue_text("&;&#;&#x;&#12a;&#1114112;&#xD800;&#0;&bogus;");
        queue_text("&abcdefghijklmnopqrstuvwxyz0123456X");
        queue_text("&a&amp;");
        queue_byte(KIND_TEXT, 8'h00);
        queue_byte(KIND_TEXT, 8'hFF);
        queue_text("&ab&c");
        queue_byte(KIND_FLUSH, 8'hA5);
        queue_byte(KIND_FLUSH, 8'h5A);
        wait_drain();

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 75;
                recv_idle_pct = 9;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 2) == 0)
                    queue_byte(KIND_TEXT, 8'($urandom_range(0, 255)));
                else queue_random_ref();
            end
            wait_drain();
        end
        stimulus_done = 1;
    end

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_decode('{kind: s_axis_tuser, data: s_axis_tdata});
                beats_in++;
            end
            if (pending_beats.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                t_in_beat beat;
                beat = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= beat.kind;
                s_axis_tdata  <= beat.data;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_out++;
                if (decoded_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end else begin
                    t_out_beat exp_b;
                    exp_b = decoded_bytes.pop_front();
                    if (m_axis_tdata !== exp_b.data)
                        report_mismatch($sformatf("byte %02h, expected %02h",
                                                  m_axis_tdata, exp_b.data));
                    if (m_axis_tlast !== exp_b.last)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  m_axis_tlast, exp_b.last));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Run control
    initial begin
        cycles    = 0;
        beats_in  = 0;
        bytes_out = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout with %0d bytes outstanding", decoded_bytes.size());
                $display("TEST FAILED");
                $finish;
            end
            if (stimulus_done) begin
                repeat (200) @(posedge i_clk);
                if (decoded_bytes.size() > 0)
                    report_mismatch($sformatf("%0d bytes never came", decoded_bytes.size()));
                $display("covered %0d input beats (text and end-of-text) and %0d output bytes",
                         beats_in, bytes_out);
                $display("named, numeric, invalid, overflow and flush references exercised");
                if (errors == 0) begin
                    $display("TEST PASSED");
                end else begin
                    $display("TEST FAILED");
                end
                $finish;
            end
        end
    end

endmodule
